// ----- rtl/tmh_pkg.sv -----
// Package for the indexed timer min-heap unit.
// Item types, entry layout, codes and sizing constants; no dependencies.
package tmh_pkg;

    localparam int CAPACITY    = 1024;
    localparam int ADDR_BITS   = 10;
    localparam int COUNT_BITS  = 11;
    localparam int HANDLE_BITS = 16;
    localparam int KEY_BITS    = 64;
    localparam int MAX_UPDATES = 11;
    localparam int UPD_BITS    = 4;

    typedef enum logic [0:0] {
        OP_PUT    = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        KIND_UPDATE  = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]    deadline;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef struct packed {
        logic                   op;
        logic [ADDR_BITS-1:0]   pos;
        logic [HANDLE_BITS-1:0] handle;
        logic [KEY_BITS-1:0]    deadline;
    } in_item_t;

    typedef struct packed {
        logic                   kind;
        logic [HANDLE_BITS-1:0] handle_res;
        logic [ADDR_BITS-1:0]   new_pos;
        logic [COUNT_BITS-1:0]  count;
        logic                   top_valid;
        logic [KEY_BITS-1:0]    top_deadline;
        logic [HANDLE_BITS-1:0] top_handle;
        logic [1:0]             status;
        logic                   last;
    } out_item_t;

endpackage

// ----- rtl/indexed_timer_min_heap_unit.sv -----
// Indexed timer min-heap: top level, control sequencer around one heap RAM.
// Depends on tmh_pkg and tmh_ram.
//
// One item at a time: s_ready is high only while the sequencer is idle. Every
// operation passes through accept, final write-back, root read and summary.
// A valid remove adds a fetch of the last entry. An operation that moves
// nothing (bad position, full heap, removal of the last entry) skips the final
// write-back. A resift at a nonzero position first checks the parent
// (parent read, compare). Each level climbed takes a parent read and a
// compare/write-back. Each level descended takes a left read, a right read and
// a compare/write-back. The closing down check is a bare index check at a leaf
// and the full left read, right read and compare otherwise. The single read
// port of the heap RAM sets this order. Every position write-back yields one
// update item, up to MAX_UPDATES per operation, and a summary item (last = 1)
// closes each operation. An output register decouples m_ready, and a stalled
// output holds the sequencer.
module indexed_timer_min_heap_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tmh_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output tmh_pkg::out_item_t m_item
);
    import tmh_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_LAST_WT = 11'b00000000010,
        S_PAR_RD  = 11'b00000000100,
        S_PAR_CMP = 11'b00000001000,
        S_DN_RDL  = 11'b00000010000,
        S_DN_RDR  = 11'b00000100000,
        S_DN_CMP  = 11'b00001000000,
        S_PLACE   = 11'b00010000000,
        S_SUM_RD  = 11'b00100000000,
        S_SUM     = 11'b01000000000,
        S_SPARE   = 11'b10000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_BITS-1:0]  pos_reg, pos_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    entry_t                ent_reg, ent_next;
    entry_t                left_reg, left_next;
    logic                  lv_reg, lv_next;
    logic                  rv_reg, rv_next;
    logic                  up_reg, up_next;
    status_t               status_reg, status_next;
    logic [UPD_BITS-1:0]   upd_cnt_reg, upd_cnt_next;
    logic                  m_valid_reg;
    out_item_t             m_item_reg;

    // RAM port signals
    logic                  ram_we, ram_re;
    logic [ADDR_BITS-1:0]  ram_waddr, ram_raddr;
    entry_t                ram_wdata, ram_rdata;
    logic [ENTRY_BITS-1:0] rdata_bits;

    // emit control
    logic                  out_free;
    logic                  emit;
    out_item_t             emit_item;

    // address helpers
    logic [ADDR_BITS-1:0]  parent;
    logic [COUNT_BITS-1:0] left_idx, right_idx;
    logic                  l_lt, r_lt, r_lt_l;

    tmh_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (CAPACITY)
    ) u_heap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata_bits)
    );
    assign ram_rdata = entry_t'(rdata_bits);

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    assign parent    = (pos_reg - ADDR_BITS'(1)) >> 1;
    assign left_idx  = {pos_reg, 1'b1};
    assign right_idx = {pos_reg, 1'b0} + COUNT_BITS'(2);

    // child comparisons done in parallel, then selected
    assign l_lt   = left_reg.deadline < ent_reg.deadline;
    assign r_lt   = ram_rdata.deadline < ent_reg.deadline;
    assign r_lt_l = ram_rdata.deadline < left_reg.deadline;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        ent_next     = ent_reg;
        left_next    = left_reg;
        lv_next      = lv_reg;
        rv_next      = rv_reg;
        up_next      = up_reg;
        status_next  = status_reg;
        upd_cnt_next = upd_cnt_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = ent_reg;
        ram_re       = 1'b0;
        ram_raddr    = parent;
        emit         = 1'b0;
        emit_item    = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    status_next  = ST_OK;
                    upd_cnt_next = '0;
                    up_next      = 1'b0;
                    ent_next     = '{deadline: s_item.deadline, handle: s_item.handle};
                    if (s_item.op == OP_PUT) begin
                        if (COUNT_BITS'(s_item.pos) < cnt_reg) begin
                            pos_next   = s_item.pos;
                            state_next = (s_item.pos == '0) ? S_DN_RDL : S_PAR_RD;
                        end else if (cnt_reg == COUNT_BITS'(CAPACITY)) begin
                            status_next = ST_FULL;
                            state_next  = S_SUM_RD;
                        end else begin
                            pos_next   = cnt_reg[ADDR_BITS-1:0];
                            cnt_next   = cnt_reg + COUNT_BITS'(1);
                            state_next = (cnt_reg == '0) ? S_DN_RDL : S_PAR_RD;
                        end
                    end else begin
                        if (COUNT_BITS'(s_item.pos) >= cnt_reg) begin
                            status_next = ST_BAD_POS;
                            state_next  = S_SUM_RD;
                        end else begin
                            // fetch the last entry to fill the hole
                            pos_next   = s_item.pos;
                            ram_re     = 1'b1;
                            ram_raddr  = ADDR_BITS'(cnt_reg - COUNT_BITS'(1));
                            state_next = S_LAST_WT;
                        end
                    end
                end
            end

            S_LAST_WT: begin
                ent_next = ram_rdata;
                cnt_next = cnt_reg - COUNT_BITS'(1);
                if (COUNT_BITS'(pos_reg) < cnt_reg - COUNT_BITS'(1)) begin
                    state_next = (pos_reg == '0) ? S_DN_RDL : S_PAR_RD;
                end else begin
                    state_next = S_SUM_RD;
                end
            end

            S_PAR_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = parent;
                state_next = S_PAR_CMP;
            end

            // parent larger: move it down and keep climbing
            S_PAR_CMP: begin
                if (ram_rdata.deadline > ent_reg.deadline) begin
                    if (out_free) begin
                        ram_we       = 1'b1;
                        ram_waddr    = pos_reg;
                        ram_wdata    = ram_rdata;
                        emit         = upd_cnt_reg < UPD_BITS'(MAX_UPDATES);
                        emit_item.kind       = KIND_UPDATE;
                        emit_item.handle_res = ram_rdata.handle;
                        emit_item.new_pos    = pos_reg;
                        upd_cnt_next = upd_cnt_reg + UPD_BITS'(emit);
                        pos_next     = parent;
                        up_next      = 1'b1;
                        state_next   = (parent == '0) ? S_PLACE : S_PAR_RD;
                    end
                end else begin
                    state_next = up_reg ? S_PLACE : S_DN_RDL;
                end
            end

            S_DN_RDL: begin
                lv_next    = left_idx < cnt_reg;
                rv_next    = right_idx < cnt_reg;
                ram_re     = left_idx < cnt_reg;
                ram_raddr  = left_idx[ADDR_BITS-1:0];
                state_next = (left_idx < cnt_reg) ? S_DN_RDR : S_PLACE;
            end

            S_DN_RDR: begin
                left_next  = ram_rdata;
                ram_re     = rv_reg;
                ram_raddr  = right_idx[ADDR_BITS-1:0];
                state_next = S_DN_CMP;
            end

            // pick the smaller child; left wins ties, no move on equal keys
            S_DN_CMP: begin
                logic   take_l, take_r;
                entry_t best;
                take_r = rv_reg && (l_lt ? r_lt_l : r_lt);
                take_l = lv_reg && l_lt && !take_r;
                best   = take_r ? ram_rdata : left_reg;
                if (take_l || take_r) begin
                    if (out_free) begin
                        ram_we       = 1'b1;
                        ram_waddr    = pos_reg;
                        ram_wdata    = best;
                        emit         = upd_cnt_reg < UPD_BITS'(MAX_UPDATES);
                        emit_item.kind       = KIND_UPDATE;
                        emit_item.handle_res = best.handle;
                        emit_item.new_pos    = pos_reg;
                        upd_cnt_next = upd_cnt_reg + UPD_BITS'(emit);
                        pos_next     = take_r ? right_idx[ADDR_BITS-1:0]
                                              : left_idx[ADDR_BITS-1:0];
                        state_next   = S_DN_RDL;
                    end
                end else begin
                    state_next = S_PLACE;
                end
            end

            // final write of the sifted entry
            S_PLACE: begin
                if (out_free) begin
                    ram_we       = 1'b1;
                    ram_waddr    = pos_reg;
                    ram_wdata    = ent_reg;
                    emit         = upd_cnt_reg < UPD_BITS'(MAX_UPDATES);
                    emit_item.kind       = KIND_UPDATE;
                    emit_item.handle_res = ent_reg.handle;
                    emit_item.new_pos    = pos_reg;
                    upd_cnt_next = upd_cnt_reg + UPD_BITS'(emit);
                    state_next   = S_SUM_RD;
                end
            end

            S_SUM_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = S_SUM;
            end

            S_SUM: begin
                if (out_free) begin
                    emit                   = 1'b1;
                    emit_item.kind         = KIND_SUMMARY;
                    emit_item.count        = cnt_reg;
                    emit_item.top_valid    = cnt_reg != '0;
                    emit_item.top_deadline = (cnt_reg != '0) ? ram_rdata.deadline : '0;
                    emit_item.top_handle   = (cnt_reg != '0) ? ram_rdata.handle : '0;
                    emit_item.status       = status_reg;
                    emit_item.last         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        ent_reg     <= ent_next;
        left_reg    <= left_next;
        lv_reg      <= lv_next;
        rv_reg      <= rv_next;
        up_reg      <= up_next;
        status_reg  <= status_next;
        upd_cnt_reg <= upd_cnt_next;
        if (emit) begin
            m_item_reg <= emit_item;
        end
    end

endmodule

// ----- rtl/tmh_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- tb/sv/indexed_timer_min_heap_unit_tb.sv -----
// Testbench for the indexed timer min-heap unit: directed and random puts and
// removes, each result checked against a heap model kept in the testbench.
// Depends on tmh_pkg and the unit RTL.
`timescale 1ns / 1ps

module indexed_timer_min_heap_unit_tb;
    import tmh_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    indexed_timer_min_heap_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Heap model
    logic [KEY_BITS-1:0]    mdl_key [CAPACITY];
    logic [HANDLE_BITS-1:0] mdl_hdl [CAPACITY];
    int unsigned            mdl_count;
    int                     upd_n;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        no_idle = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // queue helpers
    function automatic void add_expected(out_item_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void add_item(in_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void store_entry(int unsigned p, logic [KEY_BITS-1:0] k,
                                        logic [HANDLE_BITS-1:0] h);
        out_item_t r;
        mdl_key[p] = k;
        mdl_hdl[p] = h;
        if (upd_n < MAX_UPDATES) begin
            r = '0;
            r.kind = KIND_UPDATE;
            r.handle_res = h;
            r.new_pos = p[ADDR_BITS-1:0];
            add_expected(r);
            upd_n++;
        end
    endfunction

    function automatic void resift_entry(int unsigned p);
        logic [KEY_BITS-1:0]    k, bv;
        logic [HANDLE_BITS-1:0] h;
        int unsigned            par, l, rr, best;
        k = mdl_key[p];
        h = mdl_hdl[p];
        if (p > 0 && mdl_key[(p - 1) / 2] > k) begin
            // walk up
            while (p > 0) begin
                par = (p - 1) / 2;
                if (!(mdl_key[par] > k)) break;
                store_entry(p, mdl_key[par], mdl_hdl[par]);
                p = par;
            end
        end else begin
            // walk down, left child wins ties
            forever begin
                l = 2 * p + 1;
                rr = 2 * p + 2;
                best = p;
                bv = k;
                if (l < mdl_count && mdl_key[l] < bv) begin
                    best = l;
                    bv = mdl_key[l];
                end
                if (rr < mdl_count && mdl_key[rr] < bv) best = rr;
                if (best == p) break;
                store_entry(p, mdl_key[best], mdl_hdl[best]);
                p = best;
            end
        end
        store_entry(p, k, h);
    endfunction

    function automatic void predict_heap_op(in_item_t it);
        out_item_t   s;
        int unsigned p;
        status_t     st;
        p = it.pos;
        st = ST_OK;
        upd_n = 0;
        if (it.op == OP_PUT) begin
            if (p < mdl_count) begin
                mdl_key[p] = it.deadline;
                mdl_hdl[p] = it.handle;
                resift_entry(p);
            end else if (mdl_count >= CAPACITY) begin
                st = ST_FULL;
            end else begin
                p = mdl_count;
                mdl_key[p] = it.deadline;
                mdl_hdl[p] = it.handle;
                mdl_count++;
                resift_entry(p);
            end
        end else begin
            if (p >= mdl_count) begin
                st = ST_BAD_POS;
            end else begin
                mdl_key[p] = mdl_key[mdl_count - 1];
                mdl_hdl[p] = mdl_hdl[mdl_count - 1];
                mdl_count--;
                if (p < mdl_count) resift_entry(p);
            end
        end
        s = '0;
        s.kind = KIND_SUMMARY;
        s.count = mdl_count[COUNT_BITS-1:0];
        if (mdl_count > 0) begin
            s.top_valid = 1'b1;
            s.top_deadline = mdl_key[0];
            s.top_handle = mdl_hdl[0];
        end
        s.status = st;
        s.last = 1'b1;
        add_expected(s);
    endfunction

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && s_ready) begin
            predict_heap_op(s_item);
            if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 6)) begin
                s_item <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end else if (!s_valid && pending_items.size() > 0
                     && (no_idle || $urandom_range(99) >= 6)) begin
            s_item <= pending_items.pop_front();
            s_valid <= 1'b1;
        end
    end

    // Monitor
    always @(posedge aclk) begin
        out_item_t e;
        cycle_count <= cycle_count + 1;
        m_ready <= aresetn && (no_idle || $urandom_range(99) >= 6);
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = expected_results.pop_front();
                if (m_item.kind !== e.kind) report_mismatch("kind");
                if (m_item.handle_res !== e.handle_res) report_mismatch("handle_res");
                if (m_item.new_pos !== e.new_pos) report_mismatch("new_pos");
                if (m_item.count !== e.count) report_mismatch("count");
                if (m_item.top_valid !== e.top_valid) report_mismatch("top_valid");
                if (m_item.top_deadline !== e.top_deadline)
                    report_mismatch("top_deadline");
                if (m_item.top_handle !== e.top_handle) report_mismatch("top_handle");
                if (m_item.status !== e.status) report_mismatch("status");
                if (m_item.last !== e.last) report_mismatch("last");
            end
        end
    end

    // Timeout
    always @(posedge aclk) begin
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("indexed_timer_min_heap_unit test failed");
            $finish;
        end
    end

    function automatic in_item_t make_op(op_t op, int unsigned p,
                                         logic [HANDLE_BITS-1:0] h,
                                         logic [KEY_BITS-1:0] k);
        in_item_t it;
        it.op = op;
        it.pos = p[ADDR_BITS-1:0];
        it.handle = h;
        it.deadline = k;
        return it;
    endfunction

    function automatic logic [KEY_BITS-1:0] rand_key();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(20));
            2: return {32'hFFFF_FFFF, $urandom};
            default: return 64'($urandom_range(1000));
        endcase
    endfunction

    // sampled away from the rising edge so driver updates have settled
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
    endtask

    // Stimulus
    initial begin
        int          sim_count;
        int unsigned p;
        op_t         op;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-heap cases, extremes, ties, removal of last entry
        add_item(make_op(OP_REMOVE, 0, 16'h0, 64'h0));
        add_item(make_op(OP_REMOVE, 1023, 16'hFFFF, '1));
        add_item(make_op(OP_PUT, 1023, 16'hFFFF, '1));
        add_item(make_op(OP_PUT, 0, 16'h0000, 64'h0));
        add_item(make_op(OP_PUT, 5, 16'h1234, 64'd50));
        add_item(make_op(OP_PUT, 5, 16'h2345, 64'd50));
        add_item(make_op(OP_PUT, 9, 16'h3456, 64'd50));
        add_item(make_op(OP_PUT, 0, 16'hAAAA, 64'd50));
        add_item(make_op(OP_PUT, 0, 16'h5555, 64'd60));
        add_item(make_op(OP_PUT, 4, 16'h00FF, 64'd1));
        add_item(make_op(OP_PUT, 2, 16'hFF00, '1));
        add_item(make_op(OP_REMOVE, 0, 16'h0, 64'h0));
        add_item(make_op(OP_REMOVE, 6, 16'h0, 64'h0));
        add_item(make_op(OP_REMOVE, 3, 16'h0, 64'h0));
        add_item(make_op(OP_REMOVE, 1, 16'h0, 64'h0));
        add_item(make_op(OP_REMOVE, 0, 16'h0, 64'h0));
        add_item(make_op(OP_REMOVE, 0, 16'h0, 64'h0));
        add_item(make_op(OP_REMOVE, 0, 16'h0, 64'h0));
        add_item(make_op(OP_REMOVE, 0, 16'h0, 64'h0));
        wait_drained();

        // Random puts and removes, tracked count keeps positions meaningful
        sim_count = 0;
        for (int i = 0; i < 250; i++) begin
            if (i == 100) begin
                wait_drained();
                no_idle = 1'b1;
            end
            if (i == 160) begin
                wait_drained();
                no_idle = 1'b0;
            end
            op = ($urandom_range(99) < 60) ? OP_PUT : OP_REMOVE;
            if ($urandom_range(19) == 0)
                p = $urandom_range(1023);
            else if (sim_count > 0 && $urandom_range(2) != 0)
                p = $urandom_range(sim_count - 1);
            else
                p = sim_count + $urandom_range(3);
            if (op == OP_PUT && p >= sim_count && sim_count < CAPACITY) sim_count++;
            else if (op == OP_REMOVE && p < sim_count) sim_count--;
            add_item(make_op(op, p, 16'($urandom), rand_key()));
        end

        // Tail: puts at the top position, then a random mix
        add_item(make_op(OP_PUT, 1023, 16'hBEEF, 64'd7));
        add_item(make_op(OP_PUT, 1023, 16'hBEEF, 64'd0));
        for (int i = 0; i < 30; i++)
            add_item(make_op($urandom_range(1) ? OP_PUT : OP_REMOVE,
                             $urandom_range(1000), 16'($urandom),
                             rand_key()));
        wait_drained();
        repeat (200) @(posedge aclk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("indexed_timer_min_heap_unit test passed");
        end else begin
            $display("indexed_timer_min_heap_unit test failed");
        end
        $finish;
    end

endmodule
